// ===== hdl/bpa_pkg.sv =====
// shared types, constants and helpers of the bitmap page allocator
`default_nettype none

package bpa_pkg;

    localparam int WORD_BITS        = 64;
    localparam int OFF_W            = 6;
    localparam int SIZE_W           = 7;
    localparam int PAGE_W           = 15;
    localparam int WIU_W            = 10;
    localparam int BITMAP_WORDS_DEF = 512;

    localparam logic [WIU_W-1:0]  WIU_RESET = 10'd512;
    localparam logic [SIZE_W-1:0] SIZE_MAX  = 7'd64;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [SIZE_W-1:0] size_pages;
        logic [PAGE_W-1:0] page_index;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [PAGE_W-1:0] page_start;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_ALLOC_WR,
        ST_FREE_RD,
        ST_FREE_WR
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic clear;
        logic scan;
        logic alloc_wr;
        logic free_rd;
        logic free_wr;
        logic finish;
        logic fin_ok;
        logic fin_alloc;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic size_ok;
        logic is_free;
        logic free_in_range;
        logic found;
        logic exhausted;
        logic clear_last;
    } ctrl_stat_t;

    // low run of ones, whole word for 64 or more
    function automatic logic [WORD_BITS-1:0] run_mask(input logic [SIZE_W-1:0] size);
        logic [WORD_BITS-1:0] m;
        if (size >= SIZE_MAX)
        begin
            m = '1;
        end
        else
        begin
            m = (64'd1 << size) - 64'd1;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bitmap_page_allocator_unit.sv =====
// Bitmap page allocator: first-fit allocate and free of 1 to 64 page runs
// within 64-page bitmap words. After reset the block clears its bitmap memory,
// one word a cycle, holding busy high until every word is cleared. A request is
// taken when start is high and busy is low. A bad size, or a free beyond the
// heap, answers on the next cycle. A free reads the word, writes it back and
// then gives the result. An allocate reads one word a cycle through a two-stage
// search pipeline over words_in_use words, saturated at BITMAP_WORDS, and
// reports the first run that it finds, or a failure once every word is
// searched. done pulses for one cycle with the result and cannot be held off,
// so the receiver must take it then.
`default_nettype none

module bitmap_page_allocator_unit
    import bpa_pkg::*;
#(
    parameter int BITMAP_WORDS = BITMAP_WORDS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire req_t             req,
    output logic                  busy,
    output logic                  done,
    output rsp_t                  result,
    input  wire logic             cfg_we,
    input  wire logic [WIU_W-1:0] cfg_wdata
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    bpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    bpa_datapath #(
        .BITMAP_WORDS (BITMAP_WORDS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== hdl/bpa_ctrl.sv =====
// controller state machine of the bitmap page allocator
`default_nettype none

module bpa_ctrl
    import bpa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire ctrl_stat_t stat,
    output ctrl_cmd_t       cmd,
    output logic            busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start && stat.size_ok)
                begin
                    if (!stat.is_free)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (stat.free_in_range)
                    begin
                        state_next = ST_FREE_RD;
                    end
                end
            end
            ST_SCAN:
            begin
                if (stat.found)
                begin
                    state_next = ST_ALLOC_WR;
                end
                else if (stat.exhausted)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ALLOC_WR: state_next = ST_IDLE;
            ST_FREE_RD:  state_next = ST_FREE_WR;
            ST_FREE_WR:  state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    // bad size or free beyond the heap answers at once
                    if (!stat.size_ok || (stat.is_free && !stat.free_in_range))
                    begin
                        cmd.finish = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (!stat.found && stat.exhausted)
                begin
                    cmd.finish = 1'b1;
                end
            end
            ST_ALLOC_WR:
            begin
                cmd.alloc_wr  = 1'b1;
                cmd.finish    = 1'b1;
                cmd.fin_ok    = 1'b1;
                cmd.fin_alloc = 1'b1;
            end
            ST_FREE_RD:
            begin
                cmd.free_rd = 1'b1;
            end
            ST_FREE_WR:
            begin
                cmd.free_wr = 1'b1;
                cmd.finish  = 1'b1;
                cmd.fin_ok  = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/bpa_datapath.sv =====
// bitmap memory, scan pipeline, run search and result register
`default_nettype none

module bpa_datapath
    import bpa_pkg::*;
#(
    parameter int BITMAP_WORDS = BITMAP_WORDS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire req_t             req,
    input  wire ctrl_cmd_t        cmd,
    input  wire logic             cfg_we,
    input  wire logic [WIU_W-1:0] cfg_wdata,
    output ctrl_stat_t            stat,
    output logic                  done,
    output rsp_t                  result
);

    localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int CW = $clog2(BITMAP_WORDS + 1);
    localparam int LW = (CW > WIU_W) ? CW : WIU_W;

    logic [WORD_BITS-1:0] bitmap_mem [BITMAP_WORDS];

    logic [WIU_W-1:0]     wiu_reg;
    logic [LW-1:0]        issue_reg;
    logic                 s1_valid_reg;
    logic                 s2_valid_reg;
    logic [AW-1:0]        s1_addr_reg;
    logic [AW-1:0]        s2_addr_reg;
    logic [WORD_BITS-1:0] s2_word_reg;
    logic [WORD_BITS-1:0] cand_reg;
    logic [OFF_W-1:0]     off_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    req_t                 req_reg;
    logic                 done_reg;
    rsp_t                 result_reg;

    logic [LW-1:0]        limit;
    logic [LW-1:0]        wiu_ext;
    logic [LW-1:0]        words_ext;
    logic                 issue_more;
    logic                 advance;
    logic                 found;
    logic [WORD_BITS-1:0] cand;
    logic [WORD_BITS-1:0] req_mask;
    logic [OFF_W-1:0]     low_off;
    logic [AW-1:0]        free_addr;
    logic [AW-1:0]        raddr;
    logic [AW-1:0]        waddr;
    logic                 we;
    logic [WORD_BITS-1:0] wdata;
    logic [AW+OFF_W-1:0]  page_wide;

    // effective heap size, saturated at the memory depth
    assign wiu_ext    = LW'(wiu_reg);
    assign words_ext  = LW'(BITMAP_WORDS);
    assign limit      = (wiu_ext > words_ext) ? words_ext : wiu_ext;
    assign issue_more = issue_reg < limit;
    assign found      = s2_valid_reg && (cand_reg != '0);
    assign advance    = cmd.scan && !found;
    assign req_mask   = run_mask(req_reg.size_pages);
    assign free_addr  = AW'(req_reg.page_index[PAGE_W-1:OFF_W]);

    // status from the live request is only looked at while idle
    always_comb
    begin
        stat.size_ok       = (req.size_pages != '0) && (req.size_pages <= SIZE_MAX);
        stat.is_free       = (req.mode == MODE_FREE);
        stat.free_in_range = LW'(req.page_index[PAGE_W-1:OFF_W]) < limit;
        stat.found         = found;
        stat.exhausted     = !issue_more && !s1_valid_reg && !s2_valid_reg;
        stat.clear_last    = (issue_reg == LW'(BITMAP_WORDS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wiu_reg <= WIU_RESET;
        end
        else if (cfg_we)
        begin
            wiu_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= req;
        end
    end

    // read address counter, also the clearing pass pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            issue_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            issue_reg <= issue_reg + LW'(1);
        end
        else if (advance)
        begin
            if (issue_more)
            begin
                issue_reg <= issue_reg + LW'(1);
            end
            s1_valid_reg <= issue_more;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // candidate offsets where the whole run is free and fits in the word
    always_comb
    begin
        for (int off = 0; off < WORD_BITS; off++)
        begin
            cand[off] = (((rdata_reg >> off) & req_mask) == '0)
                     && ((8'(req_reg.size_pages) + 8'(off)) <= 8'(WORD_BITS));
        end
    end

    always_comb
    begin
        low_off = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (cand_reg[i])
            begin
                low_off = OFF_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_addr_reg <= issue_reg[AW-1:0];
            s2_addr_reg <= s1_addr_reg;
            s2_word_reg <= rdata_reg;
            cand_reg    <= cand;
        end
        if (cmd.scan && found)
        begin
            off_reg <= low_off;
        end
    end

    assign raddr = cmd.free_rd ? free_addr : issue_reg[AW-1:0];
    assign we    = cmd.clear || cmd.alloc_wr || cmd.free_wr;

    always_comb
    begin
        waddr = free_addr;
        wdata = '0;
        if (cmd.clear)
        begin
            waddr = issue_reg[AW-1:0];
        end
        else if (cmd.alloc_wr)
        begin
            waddr = s2_addr_reg;
            wdata = s2_word_reg | (req_mask << off_reg);
        end
        else if (req_reg.size_pages != SIZE_MAX)
        begin
            // bits past the end of the word drop out of the shift
            wdata = rdata_reg & ~(req_mask << req_reg.page_index[OFF_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            bitmap_mem[waddr] <= wdata;
        end
        rdata_reg <= bitmap_mem[raddr];
    end

    assign page_wide = {s2_addr_reg, off_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg.ok         <= cmd.fin_ok;
            result_reg.page_start <= cmd.fin_alloc ? PAGE_W'(page_wide) : '0;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== hdl/bpa_checker.sv =====
// port-level checks of the bitmap page allocator, bound to the top level
`default_nettype none

module bpa_checker
    import bpa_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire rsp_t result
);

    // an accepted request either answers at once or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request neither answered nor started");

    // a result only follows an accept or a cycle of work
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result transfer without a request");

    // the block is ready again when the result is shown
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy while a result transfer is shown");

    // a failed request carries no page number
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.ok) |-> (result.page_start == '0))
        else $error("failed request with nonzero page_start");

endmodule

bind bitmap_page_allocator_unit bpa_checker u_bpa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
